>>> hdl/u8dec_pkg.sv
// Package with the status codes and byte constants of the UTF-8 code point decoder.
package u8dec_pkg;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_STRAY_CONT    = 3'd1,
      STATUS_LEAD_TOO_LONG = 3'd2,
      STATUS_UNEXPECTED_END = 3'd3,
      STATUS_EXPECTED_CONT = 3'd4,
      STATUS_ABOVE_MAX     = 3'd5
   } status_type;

   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned CP_WIDTH   = 21;
   localparam int unsigned REM_WIDTH  = 2;
   localparam int unsigned CONT_BITS  = 6;

   // Top two bits of a continuation byte.
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Largest valid code point.
   localparam logic [CP_WIDTH-1:0] CP_MAX = 21'h10FFFF;

   // Continuation counts set by the lead byte.
   localparam logic [REM_WIDTH-1:0] REM_IDLE  = 2'd0;
   localparam logic [REM_WIDTH-1:0] REM_ONE   = 2'd1;
   localparam logic [REM_WIDTH-1:0] REM_TWO   = 2'd2;
   localparam logic [REM_WIDTH-1:0] REM_THREE = 2'd3;

endpackage

>>> hdl/utf8_code_point_decoder_top.sv
// UTF-8 byte stream to code point decoder with input and result registers.
//
//   channel | direction | ports                                   | moves
//   req     | in        | req_valid, req_stall, req_byte_value,   | one byte or end marker
//           |           | req_is_end                              |
//   rsp     | out       | rsp_valid, rsp_stall, rsp_code_point,   | one code point or error
//           |           | rsp_status                              |
//
// Each byte is held in the input register, then the decode logic loads the
// result register when the byte completes a code point or yields an error.
// One byte is accepted every cycle while the result side is not stalled.
// Reset is synchronous and active high; it empties both registers and
// returns the decoder to idle with an empty accumulator.
// A stall on the result side holds the result and backs up into req_stall.
module utf8_code_point_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [u8dec_pkg::BYTE_WIDTH-1:0]    req_byte_value,
   input  logic                                req_is_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [u8dec_pkg::CP_WIDTH-1:0]      rsp_code_point,
   output logic [2:0]                          rsp_status
);

   // Input register.
   logic                                in_valid_ff, in_valid_in;
   logic [u8dec_pkg::BYTE_WIDTH-1:0]    in_byte_ff;
   logic                                in_end_ff;

   // Decoder state.
   logic [u8dec_pkg::REM_WIDTH-1:0]     remaining_ff, remaining_in;
   logic [u8dec_pkg::CP_WIDTH-1:0]      acc_ff, acc_in;

   // Result register.
   logic                                out_valid_ff, out_valid_in;
   logic [u8dec_pkg::CP_WIDTH-1:0]      out_cp_ff;
   u8dec_pkg::status_type               out_status_ff;

   // Decode results for the byte in the input register.
   logic                                dec_emit;
   logic [u8dec_pkg::CP_WIDTH-1:0]      dec_cp;
   u8dec_pkg::status_type               dec_status;
   logic [u8dec_pkg::CP_WIDTH-1:0]      acc_shifted;

   logic                                req_xfer;
   logic                                advance;

   // The decode stage moves when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign acc_shifted = {acc_ff[u8dec_pkg::CP_WIDTH-u8dec_pkg::CONT_BITS-1:0],
                         in_byte_ff[u8dec_pkg::CONT_BITS-1:0]};

   // Decode one byte against the current state.
   always_comb begin
      remaining_in = remaining_ff;
      acc_in       = acc_ff;
      dec_emit     = 1'b0;
      dec_cp       = '0;
      dec_status   = u8dec_pkg::STATUS_OK;
      if (in_end_ff) begin
         if (remaining_ff != u8dec_pkg::REM_IDLE) begin
            remaining_in = u8dec_pkg::REM_IDLE;
            acc_in       = '0;
            dec_emit     = 1'b1;
            dec_status   = u8dec_pkg::STATUS_UNEXPECTED_END;
         end
      end else if (remaining_ff == u8dec_pkg::REM_IDLE) begin
         if (!in_byte_ff[7]) begin
            dec_emit = 1'b1;
            dec_cp   = {{(u8dec_pkg::CP_WIDTH-u8dec_pkg::BYTE_WIDTH){1'b0}}, in_byte_ff};
         end else if (in_byte_ff[7:6] == u8dec_pkg::CONT_TAG) begin
            acc_in     = '0;
            dec_emit   = 1'b1;
            dec_status = u8dec_pkg::STATUS_STRAY_CONT;
         end else if (!in_byte_ff[5]) begin
            remaining_in = u8dec_pkg::REM_ONE;
            acc_in       = {16'd0, in_byte_ff[4:0]};
         end else if (!in_byte_ff[4]) begin
            remaining_in = u8dec_pkg::REM_TWO;
            acc_in       = {17'd0, in_byte_ff[3:0]};
         end else if (!in_byte_ff[3]) begin
            remaining_in = u8dec_pkg::REM_THREE;
            acc_in       = {18'd0, in_byte_ff[2:0]};
         end else begin
            acc_in     = '0;
            dec_emit   = 1'b1;
            dec_status = u8dec_pkg::STATUS_LEAD_TOO_LONG;
         end
      end else if (in_byte_ff[7:6] != u8dec_pkg::CONT_TAG) begin
         remaining_in = u8dec_pkg::REM_IDLE;
         acc_in       = '0;
         dec_emit     = 1'b1;
         dec_status   = u8dec_pkg::STATUS_EXPECTED_CONT;
      end else begin
         remaining_in = remaining_ff - u8dec_pkg::REM_ONE;
         acc_in       = acc_shifted;
         if (remaining_ff == u8dec_pkg::REM_ONE) begin
            acc_in   = '0;
            dec_emit = 1'b1;
            if (acc_shifted > u8dec_pkg::CP_MAX) begin
               dec_status = u8dec_pkg::STATUS_ABOVE_MAX;
            end else begin
               dec_cp = acc_shifted;
            end
         end
      end
   end

   // Valid bits of the two registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = dec_emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         remaining_ff <= u8dec_pkg::REM_IDLE;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            remaining_ff <= remaining_in;
            acc_ff       <= acc_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_byte_value;
         in_end_ff  <= req_is_end;
      end
      if (advance && dec_emit) begin
         out_cp_ff     <= dec_cp;
         out_status_ff <= dec_status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_status     = out_status_ff;

`ifndef SYNTHESIS
   // An error result never carries a code point.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != u8dec_pkg::STATUS_OK) |-> (rsp_code_point == '0))
      else $error("error result with nonzero code point");

   // A good result never lies above the code point range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == u8dec_pkg::STATUS_OK) |-> (rsp_code_point <= u8dec_pkg::CP_MAX))
      else $error("code point above range reported as good");

   // The accumulator is empty whenever the decoder is idle.
   assert property (@(posedge clock) disable iff (reset)
      (remaining_ff == u8dec_pkg::REM_IDLE) |-> (acc_ff == '0))
      else $error("accumulator holds bits while idle");

   // An end marker always leaves the decoder idle.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_end_ff) |=> (remaining_ff == u8dec_pkg::REM_IDLE))
      else $error("decoder not idle after end of stream");

   // The decode stage never moves while a stalled result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("decode stage advanced over a stalled result");
`endif

endmodule
